// ----- sv/sha1h_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1h_pkg
// Shared types and constants of the SHA-1 engine: working variables, round
// phase codes, round constants and the initial chaining values.
// ----------------------------------------------------------------------------
package sha1h_pkg;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_work;

    // round phase: which boolean function and constant apply
    localparam logic [1:0] PH_CH   = 2'd0;
    localparam logic [1:0] PH_PAR1 = 2'd1;
    localparam logic [1:0] PH_MAJ  = 2'd2;
    localparam logic [1:0] PH_PAR2 = 2'd3;

    localparam logic [31:0] K_CH   = 32'h5A827999;
    localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

    localparam logic [31:0] H_INIT0 = 32'h67452301;
    localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
    localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
    localparam logic [31:0] H_INIT3 = 32'h10325476;
    localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic logic [31:0] round_k(input logic [1:0] ph);
        logic [31:0] k;
        case (ph)
            PH_CH:   k = K_CH;
            PH_PAR1: k = K_PAR1;
            PH_MAJ:  k = K_MAJ;
            default: k = K_PAR2;
        endcase
        return k;
    endfunction

endpackage

// ----- sv/sha1h_round.sv -----
// ----------------------------------------------------------------------------
// sha1h_round
// One SHA-1 compression round: the shared unit that the sequencer steps
// through all eighty rounds of a block.
// ----------------------------------------------------------------------------
module sha1h_round (
    input  sha1h_pkg::t_work i_work,
    input  logic [31:0]      i_w,
    input  logic [1:0]       i_phase,
    output sha1h_pkg::t_work o_work
);
    import sha1h_pkg::*;

    logic [31:0] f;
    logic [31:0] t;

    always_comb begin
        case (i_phase)
            PH_CH:   f = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            PH_MAJ:  f = (i_work.b & i_work.c) | (i_work.b & i_work.d)
                         | (i_work.c & i_work.d);
            default: f = i_work.b ^ i_work.c ^ i_work.d;
        endcase
    end

    assign t = {i_work.a[26:0], i_work.a[31:27]} + f + i_work.e + round_k(i_phase) + i_w;

    always_comb begin
        o_work.a = t;
        o_work.b = i_work.a;
        o_work.c = {i_work.b[1:0], i_work.b[31:2]};
        o_work.d = i_work.c;
        o_work.e = i_work.d;
    end

endmodule

// ----- sv/sha1_hash_engine_unit.sv -----
// ----------------------------------------------------------------------------
// sha1_hash_engine_unit
// SHA-1 digest engine: packs message bytes into a 16-word schedule window,
// compresses each full block with one shared round unit, pads on finish and
// streams out the five digest words.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                          tuser / tlast
//  s_axis    in   [7:0] data_byte                tuser: kind (1 = finish)
//  m_axis    out  [31:0] digest_word,            tlast: last_word
//                 [34:32] word_index, pad to 40
//
//  A message byte is taken only in idle; the 64th byte of a block then starts
//  the 80 rounds through the single round unit and the chaining add.
//  A finish pads the block with the 0x80 marker, zero bytes and the 64-bit
//  bit length, using a further block when the marker lands at byte 56 or later;
//  one or two block compressions follow, then 5 output transactions.
//  Reset loads the initial chaining values and clears the byte count.
//  s_axis is ready only when idle; a stalled m_axis holds the current word.
// ----------------------------------------------------------------------------
module sha1_hash_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        o_m_axis_tlast
);
    import sha1h_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_pos, n_pos;
    logic [63:0] r_count, n_count;
    logic [63:0] r_len, n_len;
    logic [23:0] r_acc, n_acc;
    logic [31:0] r_w [16];
    logic [31:0] n_w [16];
    logic [31:0] r_h [5];
    logic [31:0] n_h [5];
    t_work       r_work, n_work;
    logic [6:0]  r_rnd, n_rnd;
    logic [2:0]  r_oidx, n_oidx;
    logic        r_fin, n_fin;
    logic        r_first, n_first;
    logic        r_wrap, n_wrap;
    logic        r_done, n_done;

    logic        push;
    logic [7:0]  push_byte;
    logic        cur_wrap;
    logic [1:0]  phase;
    logic [31:0] sched;
    t_work       rnd_next;
    t_work       h_work;
    logic        s_acc;
    logic        m_acc;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc = o_m_axis_tvalid && i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tlast  = (r_oidx == 3'd4);

    always_comb begin
        case (r_oidx)
            3'd0:    o_m_axis_tdata = {5'b0, r_oidx, r_h[0]};
            3'd1:    o_m_axis_tdata = {5'b0, r_oidx, r_h[1]};
            3'd2:    o_m_axis_tdata = {5'b0, r_oidx, r_h[2]};
            3'd3:    o_m_axis_tdata = {5'b0, r_oidx, r_h[3]};
            default: o_m_axis_tdata = {5'b0, r_oidx, r_h[4]};
        endcase
    end

    always_comb begin
        if (r_rnd < 7'd20)      phase = PH_CH;
        else if (r_rnd < 7'd40) phase = PH_PAR1;
        else if (r_rnd < 7'd60) phase = PH_MAJ;
        else                    phase = PH_PAR2;
    end

    // window slot 0 holds w[i]; the new word is w[i+16]
    logic [31:0] sched_x;
    assign sched_x = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign sched   = {sched_x[30:0], sched_x[31]};

    assign h_work = '{a: r_h[0], b: r_h[1], c: r_h[2], d: r_h[3], e: r_h[4]};

    sha1h_round u_round (
        .i_work  (r_work),
        .i_w     (r_w[0]),
        .i_phase (phase),
        .o_work  (rnd_next)
    );

    // the 0x80 marker at byte 56 or later pushes the length into a further block
    assign cur_wrap = r_first ? (r_pos >= 6'd56) : r_wrap;

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_count = r_count;
        n_len   = r_len;
        n_acc   = r_acc;
        n_w     = r_w;
        n_h     = r_h;
        n_work  = r_work;
        n_rnd   = r_rnd;
        n_oidx  = r_oidx;
        n_fin   = r_fin;
        n_first = r_first;
        n_wrap  = r_wrap;
        n_done  = r_done;
        push      = 1'b0;
        push_byte = 8'h00;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (i_s_axis_tuser) begin
                        n_fin   = 1'b1;
                        n_first = 1'b1;
                        n_len   = {r_count[60:0], 3'b000};
                        n_state = S_PAD;
                    end else begin
                        push      = 1'b1;
                        push_byte = i_s_axis_tdata;
                        n_count   = r_count + 64'd1;
                    end
                end
            end
            S_PAD: begin
                push = 1'b1;
                if (r_first) begin
                    push_byte = PAD_MARK;
                    n_first   = 1'b0;
                    n_wrap    = cur_wrap;
                end else if (!r_wrap && r_pos >= 6'd56) begin
                    push_byte = r_len[63:56];
                    n_len     = {r_len[55:0], 8'h00};
                end
                if (r_pos == 6'd63 && !cur_wrap) begin
                    n_done = 1'b1;
                end
            end
            S_RND: begin
                n_work = rnd_next;
                for (int k = 0; k < 15; k++) begin
                    n_w[k] = r_w[k+1];
                end
                n_w[15] = sched;
                n_rnd   = r_rnd + 7'd1;
                if (r_rnd == 7'd79) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_h[0] = r_h[0] + r_work.a;
                n_h[1] = r_h[1] + r_work.b;
                n_h[2] = r_h[2] + r_work.c;
                n_h[3] = r_h[3] + r_work.d;
                n_h[4] = r_h[4] + r_work.e;
                n_wrap = 1'b0;
                if (r_done) begin
                    n_state = S_OUT;
                    n_oidx  = 3'd0;
                end else if (r_fin) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (m_acc) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd4) begin
                        n_h[0]  = H_INIT0;
                        n_h[1]  = H_INIT1;
                        n_h[2]  = H_INIT2;
                        n_h[3]  = H_INIT3;
                        n_h[4]  = H_INIT4;
                        n_count = 64'd0;
                        n_fin   = 1'b0;
                        n_done  = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // pack bytes big-endian; each fourth byte completes a word of the window
        if (push) begin
            n_acc = {r_acc[15:0], push_byte};
            if (r_pos[1:0] == 2'd3) begin
                for (int k = 0; k < 15; k++) begin
                    n_w[k] = r_w[k+1];
                end
                n_w[15] = {r_acc, push_byte};
            end
            n_pos = r_pos + 6'd1;
            if (r_pos == 6'd63) begin
                n_state = S_RND;
                n_work  = h_work;
                n_rnd   = 7'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= 6'd0;
            r_count <= 64'd0;
            r_h[0]  <= H_INIT0;
            r_h[1]  <= H_INIT1;
            r_h[2]  <= H_INIT2;
            r_h[3]  <= H_INIT3;
            r_h[4]  <= H_INIT4;
            r_rnd   <= 7'd0;
            r_oidx  <= 3'd0;
            r_fin   <= 1'b0;
            r_first <= 1'b0;
            r_wrap  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_count <= n_count;
            r_h     <= n_h;
            r_rnd   <= n_rnd;
            r_oidx  <= n_oidx;
            r_fin   <= n_fin;
            r_first <= n_first;
            r_wrap  <= n_wrap;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_acc  <= n_acc;
        r_w    <= n_w;
        r_work <= n_work;
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SHA-1 digest engine. Byte and finish
// transactions go in on s_axis with random gaps, and m_axis is stalled at
// random. A behavioural hash model predicts the five digest words for
// every finish, and a scoreboard checks each output word in order. Known
// digests (empty message, "abc") are typed straight into the directed table.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1h_pkg::*;

    localparam int N_WORDS    = 5;
    localparam int WDOG_LIMIT = 3000;
    localparam int TAIL_WAIT  = 300;
    localparam int RAND_ITEMS = 165;
    localparam int RAND_MSGS  = 10;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef logic [0:N_WORDS-1][31:0] t_digest;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    typedef struct {
        logic       kind;
        logic [7:0] data;
        logic       known;
        t_digest    digest;
    } t_row;

    localparam t_digest EMPTY_DIGEST = {32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef,
                                        32'h95601890, 32'hafd80709};
    localparam t_digest ABC_DIGEST   = {32'ha9993e36, 32'h4706816a, 32'hba3e2571,
                                        32'h7850c26c, 32'h9cd0d89d};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_tuser  = 1'b0;    // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;            // [31:0] digest_word, [34:32] word_index
    logic        m_tlast;

    // hash model state
    logic [31:0] h_state [N_WORDS];
    logic [7:0]  msg_block [64];
    logic [63:0] msg_len_bytes;

    t_digest_word digest_words_q [$];
    int           n_errors    = 0;
    int           idle_cycles = 0;
    int           tx_calm     = 0;
    int           rx_calm     = 0;

    t_row dir_tab [15];

    sha1_hash_engine_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // idle cycles before the next transaction; now and then a calm stretch
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    task automatic compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) begin
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        end
        for (int i = 16; i < 80; i++) begin
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = h_state[0];
        b = h_state[1];
        c = h_state[2];
        d = h_state[3];
        e = h_state[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = K_PAR1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = K_PAR2;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        h_state[0] += a;
        h_state[1] += b;
        h_state[2] += c;
        h_state[3] += d;
        h_state[4] += e;
    endtask

    task automatic reset_hash();
        h_state[0]    = H_INIT0;
        h_state[1]    = H_INIT1;
        h_state[2]    = H_INIT2;
        h_state[3]    = H_INIT3;
        h_state[4]    = H_INIT4;
        msg_len_bytes = '0;
    endtask

    // absorb one transaction; a finish pads, closes the message and yields the digest
    task automatic hash_item(input logic kind, input logic [7:0] b,
                             output logic done, output t_digest dig);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        pos  = msg_len_bytes[5:0];
        done = 1'b0;
        dig  = '0;
        if (kind == KIND_BYTE) begin
            msg_block[pos] = b;
            msg_len_bytes++;
            if (pos == 6'd63)
                compress_block();
            return;
        end
        bit_len = msg_len_bytes << 3;
        msg_block[pos] = PAD_MARK;
        for (int i = pos + 1; i < 64; i++)
            msg_block[i] = 8'h00;
        // no room for the length: close this block and add an extra one
        if (pos >= 6'd56) begin
            compress_block();
            for (int i = 0; i < 56; i++)
                msg_block[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++)
            msg_block[56+i] = bit_len[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < N_WORDS; i++)
            dig[i] = h_state[i];
        done = 1'b1;
        reset_hash();
    endtask

    task automatic send_item(input logic kind, input logic [7:0] b,
                             input logic known, input t_digest typed);
        int           gap;
        logic         done;
        t_digest      dig;
        t_digest_word dw;
        gap = draw_gap(tx_calm);
        for (int g = 0; g < gap; g++) begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        hash_item(kind, b, done, dig);
        if (done) begin
            if (known)
                dig = typed;
            for (int i = 0; i < N_WORDS; i++) begin
                dw.word = dig[i];
                dw.idx  = 3'(i);
                dw.last = (i == N_WORDS - 1);
                digest_words_q.insert(digest_words_q.size(), dw);
            end
        end
    endtask

    // drop valid and hold off until every expected word has arrived
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (digest_words_q.size() != 0)
            @(posedge clk);
    endtask

    // output scoreboard and watchdog
    always @(posedge clk) begin
        t_digest_word exp_w;
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_tvalid && m_tready) begin
                if (digest_words_q.size() == 0) begin
                    $display("%0t: unexpected digest word %h index %0d last %b",
                             $time, m_tdata[31:0], m_tdata[34:32], m_tlast);
                    n_errors++;
                end else begin
                    exp_w = digest_words_q.pop_front();
                    if (m_tdata[31:0] !== exp_w.word || m_tdata[34:32] !== exp_w.idx ||
                        m_tlast !== exp_w.last) begin
                        $display("%0t: digest word mismatch: expected %h/%0d/%b, actual %h/%0d/%b",
                                 $time, exp_w.word, exp_w.idx, exp_w.last,
                                 m_tdata[31:0], m_tdata[34:32], m_tlast);
                        n_errors++;
                    end
                end
            end
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("%0t: watchdog: no transaction for %0d cycles", $time, WDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // receiver: random stalls on m_axis
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            stall = draw_gap(rx_calm);
            for (int g = 0; g < stall; g++) begin
                @(negedge clk);
                m_tready = 1'b0;
            end
            @(negedge clk);
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // sender: directed table, then random messages
    initial begin
        int n_rand_items;
        int n_msgs;
        int len;
        dir_tab = '{
            '{KIND_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},   // empty message
            '{KIND_BYTE,   8'h61, 1'b0, '0},
            '{KIND_BYTE,   8'h62, 1'b0, '0},
            '{KIND_BYTE,   8'h63, 1'b0, '0},
            '{KIND_FINISH, 8'h00, 1'b1, ABC_DIGEST},
            '{KIND_FINISH, 8'hFF, 1'b1, EMPTY_DIGEST},   // state back to initial
            '{KIND_BYTE,   8'h00, 1'b0, '0},
            '{KIND_BYTE,   8'hFF, 1'b0, '0},
            '{KIND_BYTE,   8'h80, 1'b0, '0},
            '{KIND_BYTE,   8'h7F, 1'b0, '0},
            '{KIND_BYTE,   8'h01, 1'b0, '0},
            '{KIND_BYTE,   8'hFE, 1'b0, '0},
            '{KIND_FINISH, 8'hFF, 1'b0, '0},
            '{KIND_BYTE,   8'hFF, 1'b0, '0},
            '{KIND_FINISH, 8'h55, 1'b0, '0}
        };
        n_rand_items = 0;
        n_msgs       = 0;
        for (int i = 0; i < 64; i++)
            msg_block[i] = 8'h00;
        reset_hash();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[r])
            send_item(dir_tab[r].kind, dir_tab[r].data, dir_tab[r].known, dir_tab[r].digest);
        drain();

        // force both padding boundaries first: 56 buffered, then a full block
        while (n_rand_items < RAND_ITEMS || n_msgs < RAND_MSGS) begin
            if (n_msgs == 0)
                len = 56;
            else if (n_msgs == 1)
                len = 64;
            else begin
                case ($urandom_range(0, 7))
                    0:       len = $urandom_range(55, 65);
                    1:       len = $urandom_range(118, 122);
                    default: len = $urandom_range(0, 12);
                endcase
            end
            for (int i = 0; i < len; i++)
                send_item(KIND_BYTE, 8'($urandom_range(0, 255)), 1'b0, '0);
            if ($urandom_range(0, 5) == 0)
                drain();
            send_item(KIND_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
            n_rand_items += len + 1;
            n_msgs++;
        end

        drain();
        repeat (TAIL_WAIT) @(posedge clk);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sha1_hash_engine_unit.f -----
sv/sha1h_pkg.sv
sv/sha1h_round.sv
sv/sha1_hash_engine_unit.sv
tb/tb_top.sv
